/* hdl/sma_pkg.sv */
// Shared types and constants of the stereo mix accumulator.
package sma_pkg;

	localparam int unsigned STORE_DEPTH_DEFAULT = 2048;
	localparam int unsigned MASTER_VOLUME_RESET = 256;

	localparam int unsigned SLOT_W   = 11;
	localparam int unsigned SAMPLE_W = 16;
	localparam int unsigned VOLUME_W = 8;
	localparam int unsigned MASTER_W = 10;
	localparam int unsigned ACC_W    = 32;
	localparam int unsigned PCM_W    = 16;
	localparam int unsigned CFG_W    = 10;

	// Reduce the slot modulo the store depth by a scaled reciprocal.
	localparam int unsigned RECIP_SHIFT = 27;
	localparam int unsigned RECIP_W     = 24;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ACCUM = 2'd1,
		OP_DRAIN = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic {
		CFG_MASTER_VOLUME = 1'b0,
		CFG_OUTPUT_8BIT   = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ADDR1,
		ST_ADDR2,
		ST_ADDR3,
		ST_EXEC,
		ST_WRITEBACK,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic sweep;
		logic mem_clear;
		logic mem_read;
		logic mem_accum;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic sweep_last;
	} status_t;

endpackage

/* hdl/stereo_mix_accumulator_top.sv */
// Top level of the stereo mix accumulator.
//
// A request is taken on a rising edge where start is high and busy is low;
// operation, slot, both samples, source_8bit and both volumes are sampled
// there. Clear and accumulate give no result. A drain loads left_pcm and
// right_pcm, which keep their value until the next drain, and raises done
// for one cycle; done is registered from ST_DRAIN, which follows ST_ADDR1
// to ST_ADDR3 and ST_EXEC. The receiver cannot stall, so done is never held.
// Clear or an unused code runs ST_ADDR1 to ST_ADDR3 and ST_EXEC; accumulate
// adds ST_WRITEBACK, drain adds ST_DRAIN. The slot modulo the store depth is
// found by a reciprocal multiplier; the store is a single-port read-modify-write.
// Configuration: cfg_we with cfg_index 0 sets master_volume, index 1 sets
// output_8bit; write only while busy is low.
// After reset the block sweeps the store to zero, one slot per cycle, and
// holds busy high until the last slot is cleared; configuration writes are taken.
module stereo_mix_accumulator_top import sma_pkg::*; #(
	parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic [SLOT_W-1:0]          slot,
	input  logic signed [SAMPLE_W-1:0] sample_left,
	input  logic signed [SAMPLE_W-1:0] sample_right,
	input  logic                       source_8bit,
	input  logic [VOLUME_W-1:0]        left_volume,
	input  logic [VOLUME_W-1:0]        right_volume,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	output logic                       done,
	output logic signed [PCM_W-1:0]    left_pcm,
	output logic signed [PCM_W-1:0]    right_pcm
);

	cmd_t    cmd;
	status_t status;

	sma_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	sma_datapath #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.operation    (operation),
		.slot         (slot),
		.sample_left  (sample_left),
		.sample_right (sample_right),
		.source_8bit  (source_8bit),
		.left_volume  (left_volume),
		.right_volume (right_volume),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.left_pcm     (left_pcm),
		.right_pcm    (right_pcm)
	);

endmodule

/* hdl/sma_ctrl.sv */
// Controller state machine of the stereo mix accumulator.
module sma_ctrl import sma_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (status.sweep_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_next = ST_ADDR1;
				end
			end
			ST_ADDR1: state_next = ST_ADDR2;
			ST_ADDR2: state_next = ST_ADDR3;
			ST_ADDR3: state_next = ST_EXEC;
			ST_EXEC: begin
				unique case (status.op)
					OP_ACCUM: state_next = ST_WRITEBACK;
					OP_DRAIN: state_next = ST_DRAIN;
					OP_CLEAR,
					OP_NONE:  state_next = ST_IDLE;
				endcase
			end
			ST_WRITEBACK: state_next = ST_IDLE;
			ST_DRAIN:     state_next = ST_IDLE;
			default:      state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_SWEEP: cmd.sweep = 1'b1;
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			ST_ADDR1, ST_ADDR2, ST_ADDR3: ;
			ST_EXEC: begin
				cmd.mem_clear = (status.op == OP_CLEAR);
				cmd.mem_read  = (status.op == OP_ACCUM) || (status.op == OP_DRAIN);
			end
			ST_WRITEBACK: cmd.mem_accum = 1'b1;
			ST_DRAIN:     cmd.out_load  = 1'b1;
			default: ;
		endcase
	end

endmodule

/* hdl/sma_datapath.sv */
// Datapath of the stereo mix accumulator: scaling, slot reduction, store, drain.
module sma_datapath import sma_pkg::*; #(
	parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output status_t                    status,
	input  logic [1:0]                 operation,
	input  logic [SLOT_W-1:0]          slot,
	input  logic signed [SAMPLE_W-1:0] sample_left,
	input  logic signed [SAMPLE_W-1:0] sample_right,
	input  logic                       source_8bit,
	input  logic [VOLUME_W-1:0]        left_volume,
	input  logic [VOLUME_W-1:0]        right_volume,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [CFG_W-1:0]           cfg_data,
	output logic                       done,
	output logic signed [PCM_W-1:0]    left_pcm,
	output logic signed [PCM_W-1:0]    right_pcm
);

	localparam int unsigned AW    = $clog2(STORE_DEPTH);
	localparam int unsigned RECIP = (1 << RECIP_SHIFT) / STORE_DEPTH;
	localparam int unsigned DW    = 17;
	localparam int unsigned PW    = SLOT_W + RECIP_W;
	localparam int unsigned QW    = PW - RECIP_SHIFT;
	localparam int unsigned QDW   = QW + DW;
	localparam int unsigned AW1   = SAMPLE_W + VOLUME_W + 1;
	localparam int unsigned BW    = AW1 + MASTER_W + 1;

	// Configuration
	logic [MASTER_W-1:0] master_q;
	logic                out8_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= MASTER_W'(MASTER_VOLUME_RESET);
			out8_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_MASTER_VOLUME: master_q <= cfg_data;
				CFG_OUTPUT_8BIT:   out8_q   <= cfg_data[0];
			endcase
		end
	end

	// Request fields
	op_t                       op_q;
	logic [SLOT_W-1:0]         slot_q;
	logic signed [SAMPLE_W-1:0] smp_l_q, smp_r_q;
	logic                      src8_q;
	logic [VOLUME_W-1:0]       vol_l_q, vol_r_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(operation);
			slot_q  <= slot;
			smp_l_q <= sample_left;
			smp_r_q <= sample_right;
			src8_q  <= source_8bit;
			vol_l_q <= left_volume;
			vol_r_q <= right_volume;
		end
	end

	// Slot modulo depth: estimate quotient, subtract, one correction.
	logic [PW-1:0]     prod_q;
	logic [QW-1:0]     quot;
	logic [QDW-1:0]    quot_d;
	logic [SLOT_W-1:0] rem_q;
	logic [DW-1:0]     rem_fix;
	logic [AW-1:0]     addr_q;

	assign quot   = prod_q[PW-1:RECIP_SHIFT];
	assign quot_d = QDW'(quot) * QDW'(STORE_DEPTH);

	always_comb begin
		rem_fix = DW'(rem_q);
		if (rem_fix >= DW'(STORE_DEPTH)) begin
			rem_fix = rem_fix - DW'(STORE_DEPTH);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PW'(slot_q) * PW'(RECIP);
		rem_q  <= slot_q - quot_d[SLOT_W-1:0];
		addr_q <= rem_fix[AW-1:0];
	end

	// Scaling: sample * volume, then * master, then align per source width.
	logic signed [SAMPLE_W-1:0] sel_l, sel_r;
	logic signed [VOLUME_W:0]   svol_l, svol_r;
	logic signed [AW1-1:0]      a_l_q, a_r_q;
	logic signed [BW-1:0]       b_l_q, b_r_q;
	logic signed [BW-1:0]       bs_l, bs_r;
	logic [ACC_W-1:0]           add_l_q, add_r_q;

	always_comb begin
		if (src8_q) begin
			sel_l  = {{(SAMPLE_W-8){smp_l_q[7]}}, smp_l_q[7:0]};
			sel_r  = {{(SAMPLE_W-8){smp_r_q[7]}}, smp_r_q[7:0]};
			svol_l = {1'b0, vol_l_q[VOLUME_W-1:3], 3'b000};
			svol_r = {1'b0, vol_r_q[VOLUME_W-1:3], 3'b000};
		end else begin
			sel_l  = smp_l_q;
			sel_r  = smp_r_q;
			svol_l = {1'b0, vol_l_q};
			svol_r = {1'b0, vol_r_q};
		end
	end

	assign bs_l = b_l_q >>> 8;
	assign bs_r = b_r_q >>> 8;

	always_ff @(posedge clk) begin
		a_l_q   <= sel_l * svol_l;
		a_r_q   <= sel_r * svol_r;
		b_l_q   <= a_l_q * $signed({1'b0, master_q});
		b_r_q   <= a_r_q * $signed({1'b0, master_q});
		add_l_q <= src8_q ? b_l_q[ACC_W-1:0] : bs_l[ACC_W-1:0];
		add_r_q <= src8_q ? b_r_q[ACC_W-1:0] : bs_r[ACC_W-1:0];
	end

	// Clearing pass after reset
	logic [AW-1:0] sweep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_q + AW'(1);
		end
	end

	assign status.sweep_last = (sweep_q == AW'(STORE_DEPTH - 1));
	assign status.op         = op_q;

	// Accumulator store
	logic [ACC_W-1:0] mem_l [STORE_DEPTH];
	logic [ACC_W-1:0] mem_r [STORE_DEPTH];
	logic [ACC_W-1:0] rd_l_q, rd_r_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [ACC_W-1:0] wr_l, wr_r;

	always_comb begin
		wr_en   = cmd.sweep || cmd.mem_clear || cmd.mem_accum;
		wr_addr = cmd.sweep ? sweep_q : addr_q;
		if (cmd.mem_accum) begin
			wr_l = rd_l_q + add_l_q;
			wr_r = rd_r_q + add_r_q;
		end else begin
			wr_l = '0;
			wr_r = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_l[wr_addr] <= wr_l;
			mem_r[wr_addr] <= wr_r;
		end
		if (cmd.mem_read) begin
			rd_l_q <= mem_l[addr_q];
			rd_r_q <= mem_r[addr_q];
		end
	end

	// Drain: shift by 8, saturate, optionally offset to 8-bit unsigned
	function automatic logic [PCM_W-1:0] drain_pcm(input logic [ACC_W-1:0] acc,
			input logic out8);
		logic [ACC_W-9:0] val;
		logic [PCM_W-1:0] sat;
		val = acc[ACC_W-1:8];
		if (!val[ACC_W-9] && (|val[ACC_W-10:PCM_W-1])) begin
			sat = 16'h7fff;
		end else if (val[ACC_W-9] && !(&val[ACC_W-10:PCM_W-1])) begin
			sat = 16'h8000;
		end else begin
			sat = val[PCM_W-1:0];
		end
		if (out8) begin
			return {8'h00, ~sat[PCM_W-1], sat[PCM_W-2:8]};
		end
		return sat;
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			left_pcm  <= drain_pcm(rd_l_q, out8_q);
			right_pcm <= drain_pcm(rd_r_q, out8_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.out_load;
		end
	end

endmodule
